FILE: hw/rtl/dp2w_pkg.sv
// ----------------------------------------------------------------------------
// dp2w_pkg
// Shared types, register codes, constants and helpers for the depth pixel
// to world point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dp2w_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // CORDIC gain compensation, Q1.30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i), full turn mapped to 2^32
    localparam logic [31:0] ATAN_TURN [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INV_FOCAL_X  = 3'd0,
        CFG_INV_FOCAL_Y  = 3'd1,
        CFG_TILT_COS     = 3'd2,
        CFG_TILT_SIN     = 3'd3,
        CFG_MOUNT_HEIGHT = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0]        pixel_u;
        logic [11:0]        pixel_v;
        logic [15:0]        depth_mm;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        pose_heading;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } point_t;

    // Clamp to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Round Q1.30 half up to Q1.15, clamp to [-32768, 32768].
    function automatic logic signed [16:0] q30_to_q15(input logic signed [32:0] v);
        logic signed [33:0] s;
        logic signed [18:0] t;
        logic signed [16:0] r;
        s = 34'(v) + 34'sd16384;
        t = s[33:15];
        if (t > 19'sd32768)
            r = 17'sd32768;
        else if (t < -19'sd32768)
            r = -17'sd32768;
        else
            r = t[16:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/depth_pixel_to_world_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Back-projects a depth pixel through a pinhole camera and places the point
// in world coordinates using the robot pose.
// ----------------------------------------------------------------------------
// A new word is taken on every clock at which start is high; busy never
// rises, so words may stream one per cycle. Each word gives one result word
// on point, marked by a one-cycle done strobe. The pipeline length is set by
// the heading CORDIC, one micro-rotation per stage; the point path (centre
// offset, focal scaling, tilt) finishes early and waits in a delay line for
// the heading sine and cosine. The receiver cannot stall: a result is on the
// port for that one cycle only. Write the configuration registers only while
// no word is in flight.
`default_nettype none

module depth_pixel_to_world_point #(
    parameter int ANGLE_BITS    = dp2w_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = dp2w_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output      logic                             busy,
    input  wire dp2w_pkg::pixel_t                 pixel,
    output      logic                             done,
    output      dp2w_pkg::point_t                 point,
    input  wire logic                             cfg_we,
    input  wire logic [dp2w_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dp2w_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int N       = CORDIC_STAGES;
    localparam int LAT     = N + 4;        // stages 0 .. N+3
    localparam int HD_SHL  = 32 - ANGLE_BITS;
    localparam int ST_PT   = 4;            // point path done here
    localparam int ST_ROT  = N + 1;        // sine / cosine registered here
    localparam int ST_MUL  = N + 2;        // heading products here

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]        inv_focal_x_reg;
    logic [31:0]        inv_focal_y_reg;
    logic signed [15:0] tilt_cos_reg;
    logic signed [15:0] tilt_sin_reg;
    logic [15:0]        mount_height_reg;
    logic [12:0]        image_width_reg;
    logic [12:0]        image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg  <= 32'd7288100;
            inv_focal_y_reg  <= 32'd7049300;
            tilt_cos_reg     <= 16'sd16384;
            tilt_sin_reg     <= 16'sd0;
            mount_height_reg <= 16'd500;
            image_width_reg  <= 13'd640;
            image_height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (dp2w_pkg::cfg_reg_t'(cfg_index))
                dp2w_pkg::CFG_INV_FOCAL_X:  inv_focal_x_reg  <= cfg_data;
                dp2w_pkg::CFG_INV_FOCAL_Y:  inv_focal_y_reg  <= cfg_data;
                dp2w_pkg::CFG_TILT_COS:     tilt_cos_reg     <= cfg_data[15:0];
                dp2w_pkg::CFG_TILT_SIN:     tilt_sin_reg     <= cfg_data[15:0];
                dp2w_pkg::CFG_MOUNT_HEIGHT: mount_height_reg <= cfg_data[15:0];
                dp2w_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[12:0];
                dp2w_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: one bit per stage, advances every cycle
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    assign busy = 1'b0;     // fully pipelined, never holds off a word
    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 0: centre offsets (doubled, so half pixels stay exact) and
    // heading reduction to quadrant plus residual in [-1/8, 1/8) turn
    // ------------------------------------------------------------------
    logic signed [14:0] du2_next, dv2_next;
    logic [31:0]        hd_angle;
    logic [1:0]         hq_next;
    logic signed [32:0] hz_next;

    logic signed [14:0] du2_reg, dv2_reg;
    logic [15:0]        d_reg;
    logic [1:0]         hq_reg;
    logic signed [32:0] hz_reg;

    always_comb
    begin
        du2_next = $signed({2'b00, pixel.pixel_u, 1'b0}) - $signed({2'b00, image_width_reg});
        dv2_next = $signed({2'b00, pixel.pixel_v, 1'b0}) - $signed({2'b00, image_height_reg});
        // shifting out the top bits wraps the angle
        hd_angle = {16'd0, pixel.pose_heading} << HD_SHL;
        // residual taken as signed 30 bits moves the upper half to the next quadrant
        hq_next  = hd_angle[31:30] + {1'b0, hd_angle[29]};
        hz_next  = 33'($signed(hd_angle[29:0]));
    end

    always_ff @(posedge clk)
    begin
        du2_reg <= du2_next;
        dv2_reg <= dv2_next;
        d_reg   <= pixel.depth_mm;
        hq_reg  <= hq_next;
        hz_reg  <= hz_next;
    end

    // Pose rides along to the final sum.
    logic signed [31:0] pose_x_reg [0:ST_MUL];
    logic signed [31:0] pose_y_reg [0:ST_MUL];

    always_ff @(posedge clk)
    begin
        pose_x_reg[0] <= pixel.pose_x;
        pose_y_reg[0] <= pixel.pose_y;
        for (int k = 1; k <= ST_MUL; k++)
        begin
            pose_x_reg[k] <= pose_x_reg[k-1];
            pose_y_reg[k] <= pose_y_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Point path, stages 1..4
    // ------------------------------------------------------------------
    logic signed [31:0] pu_reg, pv_reg;         // stage 1: offset * depth
    logic [15:0]        d1_reg;
    logic signed [64:0] fx_prod, fy_prod;
    logic signed [46:0] xc_reg, yc_reg;         // stage 2: camera x, y (Q.16)
    logic [15:0]        d2_reg;
    logic signed [62:0] yc_c_reg, yc_s_reg;     // stage 3: tilt products
    logic signed [49:0] zc_s_reg, zc_c_reg;
    logic signed [46:0] xc3_reg;
    logic signed [33:0] zc_w;
    logic signed [63:0] yt_sum, zt_sum;
    logic signed [47:0] xr_next, yr_next;
    logic signed [48:0] zr_next;

    always_comb
    begin
        fx_prod = 65'(pu_reg * $signed({1'b0, inv_focal_x_reg}));
        fy_prod = 65'(pv_reg * $signed({1'b0, inv_focal_y_reg}));
        zc_w    = $signed({2'b00, d2_reg, 16'd0});
        yt_sum  = 64'(yc_c_reg) - 64'(zc_s_reg);
        zt_sum  = 64'(yc_s_reg) + 64'(zc_c_reg);
        // robot frame: forward is tilted z, left is minus camera x
        xr_next = zt_sum[61:14];
        yr_next = -48'(xc3_reg);
        zr_next = $signed({17'd0, mount_height_reg, 16'd0})
                - 49'($signed(yt_sum[61:14]));
    end

    always_ff @(posedge clk)
    begin
        pu_reg   <= du2_reg * $signed({1'b0, d_reg});
        pv_reg   <= dv2_reg * $signed({1'b0, d_reg});
        d1_reg   <= d_reg;
        xc_reg   <= fx_prod[63:17];
        yc_reg   <= fy_prod[63:17];
        d2_reg   <= d1_reg;
        yc_c_reg <= yc_reg * tilt_cos_reg;
        yc_s_reg <= yc_reg * tilt_sin_reg;
        zc_s_reg <= 50'(zc_w * tilt_sin_reg);
        zc_c_reg <= 50'(zc_w * tilt_cos_reg);
        xc3_reg  <= xc_reg;
    end

    // Hold the robot-frame point until the heading terms are ready.
    logic signed [47:0] xr_reg [ST_PT:ST_ROT];
    logic signed [47:0] yr_reg [ST_PT:ST_ROT];
    logic signed [48:0] zr_reg [ST_PT:ST_MUL];

    always_ff @(posedge clk)
    begin
        xr_reg[ST_PT] <= xr_next;
        yr_reg[ST_PT] <= yr_next;
        zr_reg[ST_PT] <= zr_next;
        for (int k = ST_PT + 1; k <= ST_ROT; k++)
        begin
            xr_reg[k] <= xr_reg[k-1];
            yr_reg[k] <= yr_reg[k-1];
        end
        for (int k = ST_PT + 1; k <= ST_MUL; k++)
            zr_reg[k] <= zr_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Heading CORDIC, stages 1..N, one micro-rotation per stage (Q1.30)
    // ------------------------------------------------------------------
    logic signed [32:0] cx_reg [0:N-1];
    logic signed [32:0] cy_reg [0:N-1];
    logic signed [32:0] cz_reg [0:N-1];
    logic [1:0]         cq_reg [0:N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        logic signed [32:0] x_in, y_in, z_in;
        logic [1:0]         q_in;
        logic signed [32:0] x_next, y_next, z_next;
        logic signed [32:0] atan_w;

        if (i == 0)
        begin : g_first
            assign x_in = dp2w_pkg::CORDIC_GAIN;
            assign y_in = 33'sd0;
            assign z_in = hz_reg;
            assign q_in = hq_reg;
        end
        else
        begin : g_rest
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign q_in = cq_reg[i-1];
        end

        assign atan_w = $signed({1'b0, dp2w_pkg::ATAN_TURN[i]});

        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - atan_w;
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + atan_w;
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i] <= x_next;
            cy_reg[i] <= y_next;
            cz_reg[i] <= z_next;
            cq_reg[i] <= q_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage N+1: quadrant fold, round to Q1.15
    // ------------------------------------------------------------------
    logic signed [32:0] c0_w, s0_w;
    logic signed [16:0] cr_reg, sr_reg;

    always_comb
    begin
        unique case (cq_reg[N-1])
            2'd0:
            begin
                c0_w = cx_reg[N-1];
                s0_w = cy_reg[N-1];
            end
            2'd1:
            begin
                c0_w = -cy_reg[N-1];
                s0_w = cx_reg[N-1];
            end
            2'd2:
            begin
                c0_w = -cx_reg[N-1];
                s0_w = -cy_reg[N-1];
            end
            default:
            begin
                c0_w = cy_reg[N-1];
                s0_w = -cx_reg[N-1];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cr_reg <= dp2w_pkg::q30_to_q15(c0_w);
        sr_reg <= dp2w_pkg::q30_to_q15(s0_w);
    end

    // ------------------------------------------------------------------
    // Stage N+2: heading rotation products
    // ------------------------------------------------------------------
    logic signed [64:0] xr_cr_reg, yr_sr_reg, xr_sr_reg, yr_cr_reg;

    always_ff @(posedge clk)
    begin
        xr_cr_reg <= xr_reg[ST_ROT] * cr_reg;
        yr_sr_reg <= yr_reg[ST_ROT] * sr_reg;
        xr_sr_reg <= xr_reg[ST_ROT] * sr_reg;
        yr_cr_reg <= yr_reg[ST_ROT] * cr_reg;
    end

    // ------------------------------------------------------------------
    // Stage N+3: add pose, floor shift, saturate into the output word
    // ------------------------------------------------------------------
    logic signed [65:0]    wx_sum, wy_sum;
    logic signed [34:0]    wz_w;
    dp2w_pkg::point_t      point_next;
    dp2w_pkg::point_t      point_reg;

    always_comb
    begin
        wx_sum = 66'(xr_cr_reg) - 66'(yr_sr_reg)
               + 66'($signed({pose_x_reg[ST_MUL], 31'd0}));
        wy_sum = 66'(xr_sr_reg) + 66'(yr_cr_reg)
               + 66'($signed({pose_y_reg[ST_MUL], 31'd0}));
        wz_w   = 35'($signed(zr_reg[ST_MUL][48:16]));
        point_next.world_x = dp2w_pkg::sat32(wx_sum[65:31]);
        point_next.world_y = dp2w_pkg::sat32(wy_sum[65:31]);
        point_next.world_z = dp2w_pkg::sat32(wz_w);
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

`default_nettype wire
